// ----- sv/ccud_pkg.sv -----
// Shared types, constants and calendar helper functions for the calendar clock.
// Used by ccud_ctrl, ccud_dp and calendar_clock_up_down.
`timescale 1ns / 1ps
`default_nettype none

package ccud_pkg;

    // command codes
    localparam logic [1:0] CMD_FWD  = 2'd0;
    localparam logic [1:0] CMD_BACK = 2'd1;
    localparam logic [1:0] CMD_LOAD = 2'd2;

    localparam int unsigned YEAR_MIN   = 1900;
    localparam int unsigned YEAR_MAX   = 2099;
    localparam int unsigned YEAR_SPAN  = YEAR_MAX - YEAR_MIN;
    localparam int unsigned YOFS_W     = $clog2(YEAR_SPAN + 1);
    localparam int unsigned SEC_PER_M  = 60;
    localparam int unsigned HRS_PER_D  = 24;
    localparam int unsigned DAYS_YEAR  = 365;
    localparam int unsigned DAYS_LEAP  = 366;
    localparam int unsigned DAYS_MAX   = DAYS_YEAR * YEAR_SPAN + DAYS_LEAP;

    // accumulator widths for each stage of the epoch product chain
    localparam int unsigned DAYS_W  = $clog2(DAYS_MAX + 1);
    localparam int unsigned HOURS_W = $clog2(DAYS_MAX * HRS_PER_D + 1);
    localparam int unsigned MINS_W  = $clog2(DAYS_MAX * HRS_PER_D * SEC_PER_M + 1);
    localparam int unsigned EPOCH_W = 33;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
        logic [4:0]         out_hour;
        logic [5:0]         out_minute;
        logic [5:0]         out_second;
        logic [EPOCH_W-1:0] epoch_seconds;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic step;
        logic calc_days;
        logic calc_hours;
        logic calc_mins;
        logic out_load;
    } t_dp_cmd;

    // year given as offset from 1900; 1900 is not leap, 2000 is
    function automatic logic f_is_leap(input logic [YOFS_W-1:0] yofs);
        return (yofs[1:0] == 2'd0) && (yofs != '0);
    endfunction

    function automatic logic [4:0] f_days_in(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [8:0] f_days_before(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ccud_ctrl.sv -----
// Controller for the calendar clock: sequences the clock update and epoch stages,
// and owns the handshake on both channels. Depends on ccud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccud_ctrl
    import ccud_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_HOURS,
        S_MINS,
        S_SECS
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.step       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc_days  = (r_state == S_DAYS);
        o_cmd.calc_hours = (r_state == S_HOURS);
        o_cmd.calc_mins  = (r_state == S_MINS);
        o_cmd.out_load   = (r_state == S_SECS) && w_out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DAYS;
                end
            end
            S_DAYS:  n_state = S_HOURS;
            S_HOURS: n_state = S_MINS;
            S_MINS:  n_state = S_SECS;
            S_SECS: begin
                // hold the finished product until the output register frees up
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/ccud_dp.sv -----
// Datapath for the calendar clock: clock fields, tick and load logic, the
// epoch-seconds product chain and the output register. Depends on ccud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccud_dp
    import ccud_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_item i_in_data,
    output t_out_item     o_out_data
);

    logic [YOFS_W-1:0]  r_yofs, n_yofs;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_day, n_day;
    logic [4:0]         r_hour, n_hour;
    logic [5:0]         r_min, n_min;
    logic [5:0]         r_sec, n_sec;
    logic [MINS_W-1:0]  r_acc;
    t_out_item          r_out;

    logic [YOFS_W-1:0]  w_prev_yofs;
    logic [3:0]         w_prev_month;
    logic [YOFS_W-1:0]  w_ld_yofs;
    logic [3:0]         w_ld_month;
    logic [4:0]         w_ld_dim;
    logic [4:0]         w_cur_dim;
    logic [DAYS_W-1:0]  w_days;
    logic [5:0]         w_leaps;
    logic [EPOCH_W-1:0] w_epoch;

    assign w_cur_dim = f_days_in(r_month, f_is_leap(r_yofs));

    // month and year before the first of the current month
    always_comb begin
        if (r_month > 4'd1) begin
            w_prev_month = r_month - 4'd1;
            w_prev_yofs  = r_yofs;
        end else begin
            w_prev_month = 4'd12;
            w_prev_yofs  = (r_yofs == '0) ? YOFS_W'(YEAR_SPAN) : r_yofs - 1'b1;
        end
    end

    // saturate the loaded year and month, then the day against that month
    always_comb begin
        if (i_in_data.load_year < 12'(YEAR_MIN)) begin
            w_ld_yofs = '0;
        end else if (i_in_data.load_year > 12'(YEAR_MAX)) begin
            w_ld_yofs = YOFS_W'(YEAR_SPAN);
        end else begin
            w_ld_yofs = YOFS_W'(i_in_data.load_year - 12'(YEAR_MIN));
        end
        if (i_in_data.load_month == 4'd0) begin
            w_ld_month = 4'd1;
        end else if (i_in_data.load_month > 4'd12) begin
            w_ld_month = 4'd12;
        end else begin
            w_ld_month = i_in_data.load_month;
        end
        w_ld_dim = f_days_in(w_ld_month, f_is_leap(w_ld_yofs));
    end

    always_comb begin
        n_yofs  = r_yofs;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        case (i_in_data.command)
            CMD_FWD: begin
                if (r_sec < 6'd59) begin
                    n_sec = r_sec + 6'd1;
                end else begin
                    n_sec = 6'd0;
                    if (r_min < 6'd59) begin
                        n_min = r_min + 6'd1;
                    end else begin
                        n_min = 6'd0;
                        if (r_hour < 5'd23) begin
                            n_hour = r_hour + 5'd1;
                        end else begin
                            n_hour = 5'd0;
                            if (r_day < w_cur_dim) begin
                                n_day = r_day + 5'd1;
                            end else begin
                                n_day = 5'd1;
                                if (r_month < 4'd12) begin
                                    n_month = r_month + 4'd1;
                                end else begin
                                    n_month = 4'd1;
                                    n_yofs  = (r_yofs == YOFS_W'(YEAR_SPAN)) ? '0
                                                                            : r_yofs + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            CMD_BACK: begin
                if (r_sec > 6'd0) begin
                    n_sec = r_sec - 6'd1;
                end else begin
                    n_sec = 6'd59;
                    if (r_min > 6'd0) begin
                        n_min = r_min - 6'd1;
                    end else begin
                        n_min = 6'd59;
                        if (r_hour > 5'd0) begin
                            n_hour = r_hour - 5'd1;
                        end else begin
                            n_hour = 5'd23;
                            if (r_day > 5'd1) begin
                                n_day = r_day - 5'd1;
                            end else begin
                                n_month = w_prev_month;
                                n_yofs  = w_prev_yofs;
                                n_day   = f_days_in(w_prev_month, f_is_leap(w_prev_yofs));
                            end
                        end
                    end
                end
            end
            CMD_LOAD: begin
                n_yofs  = w_ld_yofs;
                n_month = w_ld_month;
                if (i_in_data.load_day == 5'd0) begin
                    n_day = 5'd1;
                end else if (i_in_data.load_day > w_ld_dim) begin
                    n_day = w_ld_dim;
                end else begin
                    n_day = i_in_data.load_day;
                end
                n_hour = (i_in_data.load_hour > 5'd23) ? 5'd23 : i_in_data.load_hour;
                n_min  = (i_in_data.load_minute > 6'd59) ? 6'd59 : i_in_data.load_minute;
                n_sec  = (i_in_data.load_second > 6'd59) ? 6'd59 : i_in_data.load_second;
            end
            default: begin
                // unused code: leave the clock as it is
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yofs  <= '0;
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_hour  <= 5'd0;
            r_min   <= 6'd0;
            r_sec   <= 6'd0;
        end else if (i_cmd.step) begin
            r_yofs  <= n_yofs;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
        end
    end

    // leap years from 1900 up to the year before the current one
    assign w_leaps = (r_yofs == '0) ? 6'd0 : 6'((r_yofs - 1'b1) >> 2);

    assign w_days = DAYS_W'(r_yofs) * DAYS_W'(DAYS_YEAR)
                  + DAYS_W'(w_leaps)
                  + DAYS_W'(f_days_before(r_month))
                  + DAYS_W'((r_month > 4'd2) && f_is_leap(r_yofs))
                  + DAYS_W'(r_day - 5'd1);

    assign w_epoch = EPOCH_W'(r_acc) * EPOCH_W'(SEC_PER_M) + EPOCH_W'(r_sec);

    // one multiply per cycle through a shared accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_days) begin
            r_acc <= MINS_W'(w_days);
        end else if (i_cmd.calc_hours) begin
            r_acc <= MINS_W'(HOURS_W'(r_acc[DAYS_W-1:0]) * HOURS_W'(HRS_PER_D)
                           + HOURS_W'(r_hour));
        end else if (i_cmd.calc_mins) begin
            r_acc <= MINS_W'(r_acc[HOURS_W-1:0]) * MINS_W'(SEC_PER_M) + MINS_W'(r_min);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_year      <= 12'(YEAR_MIN) + 12'(r_yofs);
            r_out.out_month     <= r_month;
            r_out.out_day       <= r_day;
            r_out.out_hour      <= r_hour;
            r_out.out_minute    <= r_min;
            r_out.out_second    <= r_sec;
            r_out.epoch_seconds <= w_epoch;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ----- sv/calendar_clock_up_down.sv -----
// Calendar clock, top level: joins the controller and the datapath.
// Depends on ccud_pkg, ccud_ctrl and ccud_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request:
//   tick forward, tick back, or load a full date and time (out-of-range load
//   fields are clamped). Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns the clock after the request and the seconds since
//   1900-01-01 00:00:00.
//   The clock is updated in the accept cycle; the epoch value is then built
//   step by step in a shared accumulator (days, hours, minutes), and the
//   seconds are added as the result is written to the output register. A
//   new request is taken only once the last one has left the final stage.
//   The result sits in an output register, so the next request is taken
//   while a finished result still waits. If the receiver stalls longer, the
//   next result holds in the last stage and no further request is taken.
//   Reset (synchronous, active low) sets the clock to 1900-01-01 00:00:00
//   and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_up_down
    import ccud_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    t_dp_cmd w_cmd;

    ccud_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    ccud_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ----- dv/calendar_checker.sv -----
// Checker for the calendar clock: watches both channels, keeps its own copy
// of the clock and compares every reading that comes back.
// Depends on ccud_pkg for the request and reading types and the command codes.
`timescale 1ns / 1ps

module calendar_checker
    import ccud_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_mismatches,
    output int        o_pending
);

    int unsigned yr, mo, dy, hr, mn, sc;
    t_out_item   expected_readings[$];
    int          readings_seen;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void tick_up();
        sc++;
        if (sc < 60) return;
        sc = 0;
        mn++;
        if (mn < 60) return;
        mn = 0;
        hr++;
        if (hr < 24) return;
        hr = 0;
        dy++;
        if (dy <= month_length(yr, mo)) return;
        dy = 1;
        mo++;
        if (mo <= 12) return;
        mo = 1;
        yr = (yr >= YEAR_MAX) ? YEAR_MIN : yr + 1;
    endfunction

    function automatic void tick_down();
        if (sc > 0) begin
            sc--;
            return;
        end
        sc = 59;
        if (mn > 0) begin
            mn--;
            return;
        end
        mn = 59;
        if (hr > 0) begin
            hr--;
            return;
        end
        hr = 23;
        if (dy > 1) begin
            dy--;
            return;
        end
        if (mo > 1) begin
            mo--;
        end else begin
            mo = 12;
            yr = (yr <= YEAR_MIN) ? YEAR_MAX : yr - 1;
        end
        dy = month_length(yr, mo);
    endfunction

    // count whole years and months one by one rather than by formula
    function automatic logic [EPOCH_W-1:0] seconds_since_base();
        longint unsigned days;
        days = 0;
        for (int unsigned y = YEAR_MIN; y < yr; y++)
            days += leap_year(y) ? DAYS_LEAP : DAYS_YEAR;
        for (int unsigned m = 1; m < mo; m++)
            days += month_length(yr, m);
        days += dy - 1;
        return EPOCH_W'(((days * 24 + hr) * 60 + mn) * 60 + sc);
    endfunction

    function automatic t_out_item current_reading();
        t_out_item r;
        r.out_year      = 12'(yr);
        r.out_month     = 4'(mo);
        r.out_day       = 5'(dy);
        r.out_hour      = 5'(hr);
        r.out_minute    = 6'(mn);
        r.out_second    = 6'(sc);
        r.epoch_seconds = seconds_since_base();
        return r;
    endfunction

    function automatic void apply_request(t_in_item req);
        case (req.command)
            CMD_FWD:  tick_up();
            CMD_BACK: tick_down();
            CMD_LOAD: begin
                yr = clamp(req.load_year, YEAR_MIN, YEAR_MAX);
                mo = clamp(req.load_month, 1, 12);
                dy = clamp(req.load_day, 1, month_length(yr, mo));
                hr = clamp(req.load_hour, 0, 23);
                mn = clamp(req.load_minute, 0, 59);
                sc = clamp(req.load_second, 0, 59);
            end
            default: ;
        endcase
    endfunction

    function automatic string field_diffs(t_out_item got, t_out_item want);
        string s;
        s = "";
        if (got.out_year !== want.out_year)
            s = {s, $sformatf(" year %0d/%0d", want.out_year, got.out_year)};
        if (got.out_month !== want.out_month)
            s = {s, $sformatf(" month %0d/%0d", want.out_month, got.out_month)};
        if (got.out_day !== want.out_day)
            s = {s, $sformatf(" day %0d/%0d", want.out_day, got.out_day)};
        if (got.out_hour !== want.out_hour)
            s = {s, $sformatf(" hour %0d/%0d", want.out_hour, got.out_hour)};
        if (got.out_minute !== want.out_minute)
            s = {s, $sformatf(" minute %0d/%0d", want.out_minute, got.out_minute)};
        if (got.out_second !== want.out_second)
            s = {s, $sformatf(" second %0d/%0d", want.out_second, got.out_second)};
        if (got.epoch_seconds !== want.epoch_seconds)
            s = {s, $sformatf(" epoch %0d/%0d", want.epoch_seconds, got.epoch_seconds)};
        return s;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        string     diffs;
        if (!i_rst_n) begin
            yr = YEAR_MIN;
            mo = 1;
            dy = 1;
            hr = 0;
            mn = 0;
            sc = 0;
            expected_readings.delete();
            readings_seen = 0;
            o_mismatches  = 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                readings_seen++;
                if (expected_readings.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("reading %0d arrived with no request pending: %p",
                                 readings_seen, i_out_data);
                end else begin
                    want  = expected_readings.pop_front();
                    diffs = field_diffs(i_out_data, want);
                    if (diffs != "") begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("reading %0d mismatch (expected/actual):%s",
                                     readings_seen, diffs);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data);
                expected_readings.push_back(current_reading());
            end
            o_pending <= expected_readings.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the calendar clock testbench: clock, reset, request stimulus and
// reading backpressure, with the verdict. Depends on ccud_pkg,
// calendar_clock_up_down and calendar_checker.
`timescale 1ns / 1ps

module testbench;
    import ccud_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;   // unused code: clock holds
    localparam int NUM_REQUESTS   = 1700;
    localparam int QUIET_FROM     = 1500;
    localparam int LONG_HOLD_AT   = 600;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 1000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int        reading_errors;
    int        readings_pending;
    int        sent;
    bit        quiet;

    calendar_clock_up_down u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    calendar_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_mismatches(reading_errors),
        .o_pending   (readings_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_in_item make_load(int y, int m, int d, int h, int mi, int s);
        t_in_item r;
        r.command     = CMD_LOAD;
        r.load_year   = 12'(y);
        r.load_month  = 4'(m);
        r.load_day    = 5'(d);
        r.load_hour   = 5'(h);
        r.load_minute = 6'(mi);
        r.load_second = 6'(s);
        return r;
    endfunction

    // load fields carry junk; on non-load commands the block must ignore them
    function automatic t_in_item make_cmd(logic [1:0] cmd);
        t_in_item r;
        r         = t_in_item'({$urandom, $urandom});
        r.command = cmd;
        return r;
    endfunction

    task automatic send_request(t_in_item req);
        int gap;
        int idle_pct;
        idle_pct = (quiet || ((sent / 120) % 3 == 1)) ? 0 : 20;
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent++;
        if (sent >= QUIET_FROM) quiet = 1'b1;
    endtask

    // load a time right before (forward) or right after (back) a rollover,
    // then tick across it, now and then against the direction
    task automatic boundary_run();
        bit fwd;
        int y, m, d, h, mi, s, level, n;
        fwd   = $urandom_range(0, 1);
        level = $urandom_range(0, 4);
        case ($urandom_range(0, 7))
            0:       y = YEAR_MIN;
            1:       y = YEAR_MAX;
            2:       y = 2000;
            3:       y = YEAR_MIN + 4 * $urandom_range(0, 49);
            default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
        endcase
        m = ($urandom_range(0, 3) == 0) ? (fwd ? 12 : 1) : $urandom_range(1, 12);
        if (fwd) begin
            s  = $urandom_range(56, 59);
            mi = (level >= 1) ? 59 : $urandom_range(0, 59);
            h  = (level >= 2) ? 23 : $urandom_range(0, 23);
            d  = (level >= 3) ? 31 : $urandom_range(1, 28);
        end else begin
            s  = $urandom_range(0, 3);
            mi = (level >= 1) ? 0 : $urandom_range(0, 59);
            h  = (level >= 2) ? 0 : $urandom_range(0, 23);
            d  = (level >= 3) ? $urandom_range(0, 1) : $urandom_range(1, 28);
        end
        send_request(make_load(y, m, d, h, mi, s));
        n = $urandom_range(1, 8);
        repeat (n) begin
            if (($urandom_range(0, 4) == 0) ^ fwd)
                send_request(make_cmd(CMD_FWD));
            else
                send_request(make_cmd(CMD_BACK));
        end
    endtask

    initial begin : stimulus
        int kind;
        int n;
        sent  = 0;
        quiet = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // year wraps straight out of reset, both ways
        send_request(make_cmd(CMD_BACK));
        send_request(make_cmd(CMD_FWD));
        // all-zero and all-one load fields clamp to the ends of each range
        send_request(make_load(0, 0, 0, 0, 0, 0));
        send_request(make_load(4095, 15, 31, 31, 63, 63));
        send_request(make_cmd(CMD_FWD));
        // century year without leap day, 400-year leap, ordinary leap
        send_request(make_load(1900, 2, 31, 12, 30, 45));
        send_request(make_load(2000, 2, 31, 23, 59, 59));
        send_request(make_cmd(CMD_FWD));
        send_request(make_cmd(CMD_BACK));
        send_request(make_load(2096, 2, 29, 23, 59, 59));
        send_request(make_cmd(CMD_FWD));
        // thirty-day months, a year rollover and the unused command
        send_request(make_load(2023, 4, 31, 23, 59, 59));
        send_request(make_cmd(CMD_FWD));
        send_request(make_cmd(CMD_BACK));
        send_request(make_load(2050, 6, 15, 10, 59, 59));
        send_request(make_cmd(CMD_FWD));
        send_request(make_load(1999, 12, 31, 23, 59, 59));
        send_request(make_cmd(CMD_FWD));
        send_request(make_cmd(CMD_NOP));
        // just outside the legal ranges
        send_request(make_load(1899, 13, 0, 24, 60, 60));
        send_request(make_load(2100, 1, 1, 0, 0, 0));
        send_request(make_cmd(CMD_BACK));
        send_request(make_cmd(CMD_FWD));

        while (sent < NUM_REQUESTS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                boundary_run();
            end else if (kind < 90) begin
                send_request(make_cmd(CMD_LOAD));
                n = $urandom_range(0, 3);
                repeat (n) send_request(make_cmd($urandom_range(0, 1) ? CMD_FWD : CMD_BACK));
            end else begin
                send_request(make_cmd(CMD_NOP));
            end
        end
        in_valid <= 1'b0;

        do @(posedge i_clk); while (readings_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reading_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // reading side: short random stalls, one long hold to back up the block
    initial begin : sink
        int taken;
        int stall_left;
        int idle_pct;
        bit long_done;
        taken      = 0;
        stall_left = 0;
        long_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_valid && out_ready) taken++;
            idle_pct = (quiet || ((taken / 150) % 3 == 2)) ? 0 : 15;
            if (stall_left > 0)
                stall_left--;
            else if (!long_done && taken >= LONG_HOLD_AT) begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
            end else if ($urandom_range(0, 99) < idle_pct)
                stall_left = $urandom_range(1, 6);
            out_ready <= i_rst_n && (stall_left == 0);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
sv/ccud_pkg.sv
sv/ccud_ctrl.sv
sv/ccud_dp.sv
sv/calendar_clock_up_down.sv
dv/calendar_checker.sv
dv/testbench.sv
